### hdl/hashed_block_buffer_cache_macros.svh
// Assertion macros shared by the buffer cache RTL.
`ifndef HASHED_BLOCK_BUFFER_CACHE_MACROS_SVH
`define HASHED_BLOCK_BUFFER_CACHE_MACROS_SVH
`ifndef SYNTHESIS
`define HBBC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hbbc: same-cycle check failed");
`define HBBC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hbbc: next-cycle check failed");
`else
`define HBBC_ASSERT_IMP(lbl, ante, cons)
`define HBBC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hdl/hbbc_pkg.sv
// Shared types and codes for the hashed block buffer cache.
`default_nettype none
package hbbc_pkg;
	localparam logic [1:0] FN_GET = 2'd0;
	localparam logic [1:0] FN_DEC = 2'd1;
	localparam logic [1:0] FN_INC = 2'd2;
	localparam logic [1:0] FN_NOP = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_SAT    = 2'd2;

	typedef struct packed {
		logic [7:0]  dev;
		logic [31:0] blk;
		logic        valid;
		logic [7:0]  cnt;
	} slot_word_t;
endpackage
`default_nettype wire

### hdl/hbbc_ram.sv
// Generic single write port RAM with a registered read port.
`default_nettype none
module hbbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire                                  clk,
	input  wire                                  we,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                      wdata,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### hdl/hashed_block_buffer_cache.sv
// Top level of the hashed block buffer cache: sequencer around the tag and link memories.
`default_nettype none
`include "hashed_block_buffer_cache_macros.svh"
// After reset the block runs a clearing pass with busy high. A get first hashes the block
// number (four bits a cycle), then walks the bucket lists, where each entry visited is one
// registered read of the slot and link memories followed by its check; a miss that takes a
// slot from another bucket then relinks it into the home bucket (unlink, then push). Release
// and pin read the count and then update it; the unused code and an out-of-range slot are
// answered straight from idle. Each result appears for one cycle with done high and cannot
// be held off by the receiver; busy is already low in that cycle.
module hashed_block_buffer_cache #(
	parameter int NUM_BUFFERS = 32,
	parameter int NUM_BUCKETS = 13
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  func,
	input  wire  [7:0]  device_id,
	input  wire  [31:0] block_number,
	input  wire  [4:0]  buffer_index,
	output logic        done,
	output logic [4:0]  slot,
	output logic        was_hit,
	output logic        needs_fill,
	output logic [1:0]  status
);
	import hbbc_pkg::*;

	localparam int IW = $clog2(NUM_BUFFERS);
	localparam int LW = IW + 1;
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int RW = $clog2(2 * NUM_BUCKETS);
	localparam int INIT_N = (NUM_BUFFERS > NUM_BUCKETS) ? NUM_BUFFERS : NUM_BUCKETS;
	localparam int CW = $clog2(INIT_N + 1);
	localparam logic [LW-1:0] LNULL = LW'(NUM_BUFFERS);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CNT_RD, S_CNT_UPD, S_MOD, S_HFIRST, S_HLOAD, S_HREAD,
		S_HCHK, S_SFIRST, S_SLOAD, S_SREAD, S_SCHK, S_UNLINK, S_PUSH_A, S_PUSH_B
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   init_q;
	logic [1:0]      func_q;
	logic [7:0]      dev_q;
	logic [31:0]     blk_q;
	logic [4:0]      idx_q;
	logic [31:0]     sh_q;
	logic [2:0]      mcnt_q;
	logic [RW-1:0]   rem_q;
	logic [BW-1:0]   bk_q;
	logic [BW-1:0]   i_q;
	logic [LW-1:0]   s_q;
	logic [LW-1:0]   steps_q;
	logic [LW-1:0]   p_q;
	logic [LW-1:0]   n_q;
	logic [LW-1:0]   f_q;
	logic            done_q;
	logic [4:0]      slot_q;
	logic            hit_q;
	logic            fill_q;
	logic [1:0]      status_q;

	logic            sl_we;
	logic [IW-1:0]   sl_waddr, sl_raddr;
	slot_word_t      sl_wdata, sl_rdata;
	logic            nx_we, pv_we, fr_we;
	logic [IW-1:0]   nx_waddr, pv_waddr, lk_raddr;
	logic [LW-1:0]   nx_wdata, pv_wdata, nx_rdata, pv_rdata, fr_wdata, fr_rdata;
	logic [BW-1:0]   fr_waddr, fr_raddr;
	logic [RW-1:0]   rem_next;
	logic [BW-1:0]   home;
	logic            tag_hit, s_end, cnt_ok;

	assign home    = BW'(rem_q);
	assign tag_hit = (sl_rdata.dev == dev_q) && (sl_rdata.blk == blk_q);
	assign s_end   = (s_q >= LNULL) || (steps_q == LNULL);
	assign cnt_ok  = (func_q == FN_DEC) ? (sl_rdata.cnt != 8'd0) : (sl_rdata.cnt != 8'hFF);

	// Four steps of the remainder recurrence r = (2r + bit) mod NUM_BUCKETS per cycle.
	always_comb begin
		logic [RW-1:0] r;
		r = rem_q;
		for (int k = 0; k < 4; k++) begin
			r = RW'({r, sh_q[31-k]});
			if (r >= RW'(NUM_BUCKETS)) begin
				r = r - RW'(NUM_BUCKETS);
			end
		end
		rem_next = r;
	end

	always_comb begin
		sl_we    = 1'b0;
		sl_waddr = IW'(s_q);
		sl_wdata = sl_rdata;
		sl_raddr = IW'(s_q);
		lk_raddr = IW'(s_q);
		nx_we    = 1'b0;
		nx_waddr = IW'(s_q);
		nx_wdata = LNULL;
		pv_we    = 1'b0;
		pv_waddr = IW'(s_q);
		pv_wdata = LNULL;
		fr_we    = 1'b0;
		fr_waddr = bk_q;
		fr_wdata = LNULL;
		fr_raddr = bk_q;
		unique case (state_q)
			S_INIT: begin
				sl_we    = init_q < CW'(NUM_BUFFERS);
				sl_waddr = IW'(init_q);
				sl_wdata = '0;
				nx_we    = sl_we;
				nx_waddr = IW'(init_q);
				nx_wdata = (init_q == '0) ? LNULL : LW'(init_q - 1'b1);
				pv_we    = sl_we;
				pv_waddr = IW'(init_q);
				pv_wdata = (init_q == CW'(NUM_BUFFERS - 1)) ? LNULL : LW'(init_q + 1'b1);
				fr_we    = init_q < CW'(NUM_BUCKETS);
				fr_waddr = BW'(init_q);
				fr_wdata = (init_q == '0) ? LW'(NUM_BUFFERS - 1) : LNULL;
			end
			S_CNT_RD: begin
				sl_raddr = IW'(idx_q);
			end
			S_CNT_UPD: begin
				sl_we    = cnt_ok;
				sl_waddr = IW'(idx_q);
				sl_wdata.cnt = (func_q == FN_DEC) ? sl_rdata.cnt - 8'd1 : sl_rdata.cnt + 8'd1;
			end
			S_HFIRST: begin
				fr_raddr = home;
			end
			S_HCHK: begin
				sl_we = tag_hit && (sl_rdata.cnt != 8'hFF);
				sl_wdata.cnt   = sl_rdata.cnt + 8'd1;
				sl_wdata.valid = 1'b1;
			end
			S_SCHK: begin
				sl_we = sl_rdata.cnt == 8'd0;
				sl_wdata.dev   = dev_q;
				sl_wdata.blk   = blk_q;
				sl_wdata.valid = 1'b1;
				sl_wdata.cnt   = 8'd1;
			end
			S_UNLINK: begin
				// Unlink from the donor bucket and fetch the home head in the same cycle.
				if (p_q < LNULL) begin
					nx_we    = 1'b1;
					nx_waddr = IW'(p_q);
					nx_wdata = n_q;
				end else begin
					fr_we    = 1'b1;
					fr_wdata = n_q;
				end
				if (n_q < LNULL) begin
					pv_we    = 1'b1;
					pv_waddr = IW'(n_q);
					pv_wdata = p_q;
				end
				fr_raddr = home;
			end
			S_PUSH_A: begin
				nx_we    = 1'b1;
				nx_wdata = fr_rdata;
				pv_we    = 1'b1;
				fr_we    = 1'b1;
				fr_waddr = home;
				fr_wdata = s_q;
			end
			S_PUSH_B: begin
				pv_we    = f_q < LNULL;
				pv_waddr = IW'(f_q);
				pv_wdata = s_q;
			end
			default: begin
			end
		endcase
	end

	hbbc_ram #(.WIDTH($bits(slot_word_t)), .DEPTH(NUM_BUFFERS)) u_slot_ram (
		.clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
		.raddr(sl_raddr), .rdata(sl_rdata)
	);
	hbbc_ram #(.WIDTH(LW), .DEPTH(NUM_BUFFERS)) u_next_ram (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.raddr(lk_raddr), .rdata(nx_rdata)
	);
	hbbc_ram #(.WIDTH(LW), .DEPTH(NUM_BUFFERS)) u_prev_ram (
		.clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.raddr(lk_raddr), .rdata(pv_rdata)
	);
	hbbc_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS)) u_first_ram (
		.clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
		.raddr(fr_raddr), .rdata(fr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == CW'(INIT_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						func_q <= func;
						dev_q  <= device_id;
						blk_q  <= block_number;
						idx_q  <= buffer_index;
						sh_q   <= block_number;
						rem_q  <= '0;
						mcnt_q <= '0;
						if (func == FN_GET) begin
							state_q <= S_MOD;
						end else if (func == FN_NOP || 32'(buffer_index) >= NUM_BUFFERS) begin
							done_q   <= 1'b1;
							slot_q   <= buffer_index;
							hit_q    <= 1'b0;
							fill_q   <= 1'b0;
							status_q <= (func == FN_NOP) ? ST_OK : ST_SAT;
						end else begin
							state_q <= S_CNT_RD;
						end
					end
				end
				S_CNT_RD: state_q <= S_CNT_UPD;
				S_CNT_UPD: begin
					done_q   <= 1'b1;
					slot_q   <= idx_q;
					hit_q    <= 1'b0;
					fill_q   <= 1'b0;
					status_q <= cnt_ok ? ST_OK : ST_SAT;
					state_q  <= S_IDLE;
				end
				S_MOD: begin
					rem_q  <= rem_next;
					sh_q   <= sh_q << 4;
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd7) begin
						state_q <= S_HFIRST;
					end
				end
				S_HFIRST: state_q <= S_HLOAD;
				S_HLOAD: begin
					s_q     <= fr_rdata;
					steps_q <= '0;
					state_q <= S_HREAD;
				end
				S_HREAD: begin
					if (s_end) begin
						bk_q    <= home;
						i_q     <= '0;
						state_q <= S_SFIRST;
					end else begin
						state_q <= S_HCHK;
					end
				end
				S_HCHK: begin
					if (tag_hit) begin
						done_q   <= 1'b1;
						slot_q   <= 5'(s_q);
						hit_q    <= 1'b1;
						fill_q   <= (sl_rdata.cnt != 8'hFF) && !sl_rdata.valid;
						status_q <= (sl_rdata.cnt != 8'hFF) ? ST_OK : ST_SAT;
						state_q  <= S_IDLE;
					end else begin
						s_q     <= nx_rdata;
						steps_q <= steps_q + 1'b1;
						state_q <= S_HREAD;
					end
				end
				S_SFIRST: state_q <= S_SLOAD;
				S_SLOAD: begin
					s_q     <= fr_rdata;
					steps_q <= '0;
					state_q <= S_SREAD;
				end
				S_SREAD: begin
					if (!s_end) begin
						state_q <= S_SCHK;
					end else if (i_q == BW'(NUM_BUCKETS - 1)) begin
						done_q   <= 1'b1;
						slot_q   <= 5'd0;
						hit_q    <= 1'b0;
						fill_q   <= 1'b0;
						status_q <= ST_NOFREE;
						state_q  <= S_IDLE;
					end else begin
						i_q     <= i_q + 1'b1;
						bk_q    <= (bk_q == BW'(NUM_BUCKETS - 1)) ? '0 : bk_q + 1'b1;
						state_q <= S_SFIRST;
					end
				end
				S_SCHK: begin
					if (sl_rdata.cnt == 8'd0) begin
						p_q <= pv_rdata;
						n_q <= nx_rdata;
						if (i_q == '0) begin
							done_q   <= 1'b1;
							slot_q   <= 5'(s_q);
							hit_q    <= 1'b0;
							fill_q   <= 1'b1;
							status_q <= ST_OK;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_UNLINK;
						end
					end else begin
						s_q     <= nx_rdata;
						steps_q <= steps_q + 1'b1;
						state_q <= S_SREAD;
					end
				end
				S_UNLINK: state_q <= S_PUSH_A;
				S_PUSH_A: begin
					f_q     <= fr_rdata;
					state_q <= S_PUSH_B;
				end
				S_PUSH_B: begin
					done_q   <= 1'b1;
					slot_q   <= 5'(s_q);
					hit_q    <= 1'b0;
					fill_q   <= 1'b1;
					status_q <= ST_OK;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign slot       = slot_q;
	assign was_hit    = hit_q;
	assign needs_fill = fill_q;
	assign status     = status_q;

	`HBBC_ASSERT_NXT(a_accept_busy, start && !busy && func != FN_NOP && func != FN_DEC && func != FN_INC, busy)
	`HBBC_ASSERT_IMP(a_done_after_work, done, $past(busy) || $past(start))
	`HBBC_ASSERT_IMP(a_nofree_clean, done && status == ST_NOFREE, slot == 5'd0 && !was_hit && !needs_fill)
	`HBBC_ASSERT_IMP(a_hit_not_nofree, done && was_hit, status != ST_NOFREE)
endmodule
`default_nettype wire

### tb/sv/hbbc_checker.sv
// Checker for the hashed block buffer cache: tracks the cache state and compares every result.
`timescale 1ns / 100ps
`default_nettype none
module hbbc_checker #(
	parameter int NUM_BUFFERS = 32,
	parameter int NUM_BUCKETS = 13
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire        busy,
	input  wire  [1:0] func,
	input  wire  [7:0] device_id,
	input  wire [31:0] block_number,
	input  wire  [4:0] buffer_index,
	input  wire        done,
	input  wire  [4:0] slot,
	input  wire        was_hit,
	input  wire        needs_fill,
	input  wire  [1:0] status,
	output int         errors,
	output int         pending
);
	import hbbc_pkg::*;

	localparam int NIL = NUM_BUFFERS;

	typedef struct packed {
		logic [4:0] slot;
		logic       hit;
		logic       fill;
		logic [1:0] status;
	} cache_word_t;

	logic [7:0]  c_dev [NUM_BUFFERS];
	logic [31:0] c_blk [NUM_BUFFERS];
	logic        c_valid [NUM_BUFFERS];
	logic [7:0]  c_cnt [NUM_BUFFERS];
	int          nxt [NUM_BUFFERS];
	int          prv [NUM_BUFFERS];
	int          head [NUM_BUCKETS];
	int          tail [NUM_BUCKETS];
	cache_word_t due_words[$];

	function automatic void clear_cache();
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			head[i] = NIL;
			tail[i] = NIL;
		end
		for (int i = 0; i < NUM_BUFFERS; i++) begin
			c_dev[i] = '0;
			c_blk[i] = '0;
			c_valid[i] = 1'b0;
			c_cnt[i] = '0;
			nxt[i] = (i == 0) ? NIL : i - 1;
			prv[i] = (i == NUM_BUFFERS - 1) ? NIL : i + 1;
		end
		head[0] = NUM_BUFFERS - 1;
		tail[0] = 0;
	endfunction

	function automatic cache_word_t lookup(logic [7:0] dev, logic [31:0] blk);
		cache_word_t w;
		int home;
		int s;
		int bk;
		int p;
		int n;
		home = int'(blk % NUM_BUCKETS);
		s = head[home];
		for (int k = 0; s < NUM_BUFFERS && k < NUM_BUFFERS; k++) begin
			if (c_dev[s] == dev && c_blk[s] == blk) begin
				w.slot = s[4:0];
				w.hit = 1'b1;
				if (c_cnt[s] == 8'd255) begin
					w.fill = 1'b0;
					w.status = ST_SAT;
					return w;
				end
				c_cnt[s]++;
				w.fill = !c_valid[s];
				c_valid[s] = 1'b1;
				w.status = ST_OK;
				return w;
			end
			s = nxt[s];
		end
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			bk = (home + i) % NUM_BUCKETS;
			s = head[bk];
			for (int k = 0; s < NUM_BUFFERS && k < NUM_BUFFERS; k++) begin
				if (c_cnt[s] == 0) begin
					c_dev[s] = dev;
					c_blk[s] = blk;
					c_cnt[s] = 8'd1;
					if (i != 0) begin
						p = prv[s];
						n = nxt[s];
						if (p < NUM_BUFFERS) nxt[p] = n; else head[bk] = n;
						if (n < NUM_BUFFERS) prv[n] = p; else tail[bk] = p;
						prv[s] = NIL;
						nxt[s] = head[home];
						if (head[home] < NUM_BUFFERS) prv[head[home]] = s;
						else tail[home] = s;
						head[home] = s;
					end
					c_valid[s] = 1'b1;
					w = '{slot: s[4:0], hit: 1'b1 ^ 1'b1, fill: 1'b1, status: ST_OK};
					return w;
				end
				s = nxt[s];
			end
		end
		return '{slot: 5'd0, hit: 1'b0, fill: 1'b0, status: ST_NOFREE};
	endfunction

	function automatic cache_word_t apply_op(logic [1:0] f, logic [7:0] dev, logic [31:0] blk,
			logic [4:0] idx);
		cache_word_t w;
		w = '{slot: idx, hit: 1'b0, fill: 1'b0, status: ST_OK};
		case (f)
			FN_GET: w = lookup(dev, blk);
			FN_NOP: ;
			default: begin
				if (int'(idx) >= NUM_BUFFERS) w.status = ST_SAT;
				else if (f == FN_DEC) begin
					if (c_cnt[idx] == 0) w.status = ST_SAT;
					else c_cnt[idx]--;
				end else begin
					if (c_cnt[idx] == 8'd255) w.status = ST_SAT;
					else c_cnt[idx]++;
				end
			end
		endcase
		return w;
	endfunction

	assign pending = due_words.size();

	always @(posedge clk or negedge arst_n) begin
		cache_word_t want;
		cache_word_t got;
		if (!arst_n) begin
			clear_cache();
			due_words.delete();
			errors <= 0;
		end else begin
			// A result can come in the same cycle as the next word is accepted.
			if (done) begin
				got = '{slot: slot, hit: was_hit, fill: needs_fill, status: status};
				if (due_words.size() == 0) begin
					$display("%0t: unexpected result slot=%0d hit=%0b fill=%0b status=%0d",
						$time, slot, was_hit, needs_fill, status);
					errors <= errors + 1;
				end else begin
					want = due_words.pop_front();
					if (got !== want) begin
						$display("%0t: expected slot=%0d hit=%0b fill=%0b status=%0d,",
							$time, want.slot, want.hit, want.fill, want.status,
							" got slot=%0d hit=%0b fill=%0b status=%0d",
							got.slot, got.hit, got.fill, got.status);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				due_words.push_back(apply_op(func, device_id, block_number, buffer_index));
		end
	end
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Testbench top for the hashed block buffer cache: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import hbbc_pkg::*;

	localparam int N_RANDOM = 270;
	localparam int CYCLE_LIMIT = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  func = FN_NOP;
	logic [7:0]  device_id = '0;
	logic [31:0] block_number = '0;
	logic [4:0]  buffer_index = '0;
	wire         busy;
	wire         done;
	wire  [4:0]  slot;
	wire         was_hit;
	wire         needs_fill;
	wire  [1:0]  status;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          n_gets = 0;
	int          n_counts = 0;
	logic [31:0] recent_blk [8];
	logic [7:0]  recent_dev [8];

	always #5 clk = ~clk;

	hashed_block_buffer_cache DUT (.*);
	hbbc_checker CHK (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Presents one word and holds it until the block takes it.
	task automatic send(logic [1:0] f, logic [7:0] dev, logic [31:0] blk, logic [4:0] idx);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		device_id <= dev;
		block_number <= blk;
		buffer_index <= idx;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (f == FN_GET) n_gets++; else n_counts++;
	endtask

	initial begin
		logic [1:0] f;
		int k;
		for (int i = 0; i < 8; i++) begin
			recent_blk[i] = $urandom;
			recent_dev[i] = 8'($urandom);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: stale zero tag hit, extremes, both directions of the count, spare code.
		send(FN_GET, 8'd0, 32'd0, 5'd0);
		send(FN_GET, 8'd0, 32'd0, 5'd0);
		send(FN_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
		send(FN_GET, 8'hAA, 32'd13, 5'd0);
		send(FN_GET, 8'h55, 32'd26, 5'd0);
		send(FN_DEC, 8'd0, 32'd0, 5'd31);
		send(FN_DEC, 8'd0, 32'd0, 5'd31);
		send(FN_DEC, 8'd0, 32'd0, 5'd7);
		send(FN_INC, 8'hFF, 32'hFFFF_FFFF, 5'd7);
		send(FN_NOP, 8'hFF, 32'hFFFF_FFFF, 5'd19);
		// Pin one slot to 255 so both saturation paths are taken.
		for (int i = 0; i < 256; i++) send(FN_INC, 8'd0, 32'd0, 5'd31);
		send(FN_GET, 8'd0, 32'd0, 5'd0);
		// Hold every slot so a get finds no free buffer.
		for (int i = 0; i < 32; i++) send(FN_INC, 8'd0, 32'd0, 5'(i));
		send(FN_GET, 8'h12, 32'h1234_5678, 5'd0);
		for (int i = 0; i < 32; i++) send(FN_DEC, 8'd0, 32'd0, 5'(i));
		for (int i = 0; i < 256; i++) send(FN_DEC, 8'd0, 32'd0, 5'd31);
		for (int i = 0; i < 40; i++) send(FN_DEC, 8'd0, 32'd0, 5'(i % 32));
		// Random: half gets of a small working set, the rest releases, pins and spare codes on random slots.
		for (int n = 0; n < N_RANDOM; n++) begin
			k = $urandom_range(0, 9);
			if (k < 5) begin
				f = FN_GET;
				if ($urandom_range(0, 2) != 0) begin
					k = $urandom_range(0, 7);
					send(f, recent_dev[k], recent_blk[k], 5'($urandom));
				end else begin
					k = $urandom_range(0, 7);
					recent_blk[k] = ($urandom_range(0, 1) == 1) ? $urandom
						: 32'($urandom_range(0, 40));
					recent_dev[k] = 8'($urandom_range(0, 3));
					send(f, recent_dev[k], recent_blk[k], 5'($urandom));
				end
			end else if (k < 8) begin
				send(FN_DEC, 8'($urandom), $urandom, 5'($urandom));
			end else if (k < 9) begin
				send(FN_INC, 8'($urandom), $urandom, 5'($urandom));
			end else begin
				send(FN_NOP, 8'($urandom), $urandom, 5'($urandom));
			end
		end
		start <= 1'b0;
		k = 0;
		while (pending != 0 && k < 2000) begin
			@(posedge clk);
			k++;
		end
		repeat (100) @(posedge clk);
		$display("Ran %0d gets and %0d count updates, including saturation,", n_gets, n_counts);
		$display("empty-pool, stale-tag and spare-code cases.");
		if (errors == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
